// ===== rtl/gtrc_pkg.sv =====
// ----------------------------------------------------------------------------
// gtrc_pkg
// Shared types and constants for the GF(2) tableau rotate/canonicalize core.
// ----------------------------------------------------------------------------
package gtrc_pkg;

    localparam int COL_W      = 8;
    localparam int NUM_QUBITS = 4;
    localparam int NUM_COLS   = 2 * NUM_QUBITS;
    localparam int KEY_W      = COL_W * NUM_COLS;

    typedef logic [COL_W-1:0] col_t;
    typedef logic [KEY_W-1:0] key_t;
    typedef logic [1:0]       qubit_t;
    typedef logic [1:0]       axis_t;

    // axis mask bits
    localparam int AXIS_X_BIT = 1;
    localparam int AXIS_Z_BIT = 0;

    typedef struct packed {
        qubit_t qubit_a;
        qubit_t qubit_b;
        axis_t  axis_a;
        axis_t  axis_b;
    } rot_ctl_t;

    // local H/S word that maps the rotated pair onto the canonical pair
    typedef enum logic [2:0] {
        LOC_NONE = 3'd0,
        LOC_H    = 3'd1,
        LOC_S    = 3'd2,
        LOC_HS   = 3'd3,
        LOC_SH   = 3'd4,
        LOC_HSH  = 3'd5
    } local_t;

endpackage

// ===== rtl/gtrc_rotate.sv =====
// ----------------------------------------------------------------------------
// gtrc_rotate
// Two pipeline stages: form the change byte, then XOR it into the crossed
// columns of both named qubits.
// ----------------------------------------------------------------------------
module gtrc_rotate
    import gtrc_pkg::*;
(
    input  logic     clk,
    input  logic     adv,
    input  key_t     tableau_key,
    input  rot_ctl_t ctl,
    output key_t     rot_key
);

    col_t     cols_in [NUM_COLS];
    col_t     cols_s1 [NUM_COLS];
    col_t     chg_next;
    key_t     key2_next;

    key_t     key1_reg;
    rot_ctl_t ctl1_reg;
    col_t     chg1_reg;
    key_t     key2_reg;

    // stage 1: change byte from the selected columns (before any update)
    always_comb
    begin
        for (int i = 0; i < NUM_COLS; i++)
        begin
            cols_in[i] = tableau_key[i*COL_W +: COL_W];
        end
        chg_next = '0;
        if (ctl.axis_a[AXIS_X_BIT]) chg_next ^= cols_in[{ctl.qubit_a, 1'b0}];
        if (ctl.axis_a[AXIS_Z_BIT]) chg_next ^= cols_in[{ctl.qubit_a, 1'b1}];
        if (ctl.axis_b[AXIS_X_BIT]) chg_next ^= cols_in[{ctl.qubit_b, 1'b0}];
        if (ctl.axis_b[AXIS_Z_BIT]) chg_next ^= cols_in[{ctl.qubit_b, 1'b1}];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            key1_reg <= tableau_key;
            ctl1_reg <= ctl;
            chg1_reg <= chg_next;
        end
    end

    // stage 2: z bit of a mask feeds the x column and vice versa; a double
    // hit on one column (same qubit twice) cancels
    always_comb
    begin
        logic hit_a;
        logic hit_b;
        for (int i = 0; i < NUM_COLS; i++)
        begin
            cols_s1[i] = key1_reg[i*COL_W +: COL_W];
        end
        for (int i = 0; i < NUM_COLS; i++)
        begin
            if (i % 2 == 0)
            begin
                hit_a = ctl1_reg.axis_a[AXIS_Z_BIT] && (ctl1_reg.qubit_a == qubit_t'(i / 2));
                hit_b = ctl1_reg.axis_b[AXIS_Z_BIT] && (ctl1_reg.qubit_b == qubit_t'(i / 2));
            end
            else
            begin
                hit_a = ctl1_reg.axis_a[AXIS_X_BIT] && (ctl1_reg.qubit_a == qubit_t'(i / 2));
                hit_b = ctl1_reg.axis_b[AXIS_X_BIT] && (ctl1_reg.qubit_b == qubit_t'(i / 2));
            end
            key2_next[i*COL_W +: COL_W] = (hit_a ^ hit_b) ? (cols_s1[i] ^ chg1_reg)
                                                           : cols_s1[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            key2_reg <= key2_next;
        end
    end

    assign rot_key = key2_reg;

endmodule

// ===== rtl/gtrc_canon.sv =====
// ----------------------------------------------------------------------------
// gtrc_canon
// Canonicalizes one qubit's (x, z) pair in two stages: magnitude compares,
// then min/mid select and local word match.
// ----------------------------------------------------------------------------
module gtrc_canon
    import gtrc_pkg::*;
(
    input  logic   clk,
    input  logic   adv,
    input  col_t   x_in,
    input  col_t   z_in,
    output col_t   x_out,
    output col_t   z_out,
    output local_t loc
);

    col_t   x3_reg;
    col_t   z3_reg;
    col_t   s3_reg;
    logic   gxz_reg;
    logic   gzs_reg;
    logic   gxs_reg;

    col_t   mn;
    col_t   mx;
    col_t   md;
    local_t loc_next;

    col_t   x4_reg;
    col_t   z4_reg;
    local_t loc4_reg;

    // stage 3: pairwise compares of x, z and x^z
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x3_reg  <= x_in;
            z3_reg  <= z_in;
            s3_reg  <= x_in ^ z_in;
            gxz_reg <= x_in > z_in;
            gzs_reg <= z_in > (x_in ^ z_in);
            gxs_reg <= x_in > (x_in ^ z_in);
        end
    end

    // stage 4: x ^ z ^ (x^z) is zero, so mid = min ^ max
    always_comb
    begin
        mn = (!gxz_reg && !gxs_reg) ? x3_reg : (!gzs_reg ? z3_reg : s3_reg);
        mx = (gxz_reg && gxs_reg) ? x3_reg : (gzs_reg ? z3_reg : s3_reg);
        md = mn ^ mx;

        if (x3_reg == mn && z3_reg == md)
            loc_next = LOC_NONE;
        else if (z3_reg == mn && x3_reg == md)
            loc_next = LOC_H;
        else if (x3_reg == mn && s3_reg == md)
            loc_next = LOC_S;
        else if (z3_reg == mn && s3_reg == md)
            loc_next = LOC_HS;
        else if (s3_reg == mn && x3_reg == md)
            loc_next = LOC_SH;
        else if (s3_reg == mn && z3_reg == md)
            loc_next = LOC_HSH;
        else
            loc_next = LOC_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x4_reg   <= mn;
            z4_reg   <= md;
            loc4_reg <= loc_next;
        end
    end

    assign x_out = x4_reg;
    assign z_out = z4_reg;
    assign loc   = loc4_reg;

endmodule

// ===== rtl/gf2_tableau_rotate_canonicalize_core.sv =====
// ----------------------------------------------------------------------------
// gf2_tableau_rotate_canonicalize_core
// Applies one two-qubit rotation to a packed GF(2) tableau key and brings
// every qubit's column pair into canonical order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries tableau_key plus the rotation
//   (qubit_a, qubit_b, axis_a, axis_b). Output channel (out_valid/out_ready)
//   carries new_key and the four local word indices local_q0..local_q3.
//   One result per input, in order.
//   Four register stages: change byte, column update, compares, sort/match.
//   out_valid rises once the input has passed the change byte, column update,
//   compares and sort/match registers in that order; the last stage is the
//   output register.
//   Throughput is one item per cycle: a new item enters every cycle the
//   output register is empty or being drained.
//   When the receiver stalls with out_valid high, the whole pipe holds
//   (in_ready drops); nothing is dropped or repeated and bubbles inside the
//   pipe stay in place.
//   Reset (rst_n low) clears all stage valid bits; the pipe comes out empty
//   with in_ready high.
// ----------------------------------------------------------------------------
module gf2_tableau_rotate_canonicalize_core
    import gtrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] tableau_key,
    input  logic [1:0]  qubit_a,
    input  logic [1:0]  qubit_b,
    input  logic [1:0]  axis_a,
    input  logic [1:0]  axis_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] new_key,
    output logic [2:0]  local_q0,
    output logic [2:0]  local_q1,
    output logic [2:0]  local_q2,
    output logic [2:0]  local_q3
);

    logic     adv;
    rot_ctl_t ctl;
    key_t     rot_key;
    col_t     cx [NUM_QUBITS];
    col_t     cz [NUM_QUBITS];
    local_t   loc [NUM_QUBITS];

    logic     v1_reg;
    logic     v2_reg;
    logic     v3_reg;
    logic     v4_reg;

    // the pipe moves as one whenever the output slot is free or draining
    assign adv      = !v4_reg || out_ready;
    assign in_ready = adv;

    assign ctl = '{qubit_a: qubit_a, qubit_b: qubit_b, axis_a: axis_a, axis_b: axis_b};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    gtrc_rotate u_rotate (
        .clk         (clk),
        .adv         (adv),
        .tableau_key (tableau_key),
        .ctl         (ctl),
        .rot_key     (rot_key)
    );

    for (genvar q = 0; q < NUM_QUBITS; q++)
    begin : g_canon
        gtrc_canon u_canon (
            .clk   (clk),
            .adv   (adv),
            .x_in  (rot_key[(2*q)*COL_W +: COL_W]),
            .z_in  (rot_key[(2*q+1)*COL_W +: COL_W]),
            .x_out (cx[q]),
            .z_out (cz[q]),
            .loc   (loc[q])
        );
        assign new_key[(2*q)*COL_W +: COL_W]   = cx[q];
        assign new_key[(2*q+1)*COL_W +: COL_W] = cz[q];
    end

    assign out_valid = v4_reg;
    assign local_q0  = loc[0];
    assign local_q1  = loc[1];
    assign local_q2  = loc[2];
    assign local_q3  = loc[3];

`ifndef SYNTH
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input accepted while output stalled");

    a_stage3_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && in_ready) |=> out_valid)
        else $error("item lost between last stages");

    a_empty_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipe blocked with empty output");

    a_pair_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (new_key[7:0] <= new_key[15:8]) && (new_key[23:16] <= new_key[31:24])
                   && (new_key[39:32] <= new_key[47:40]) && (new_key[55:48] <= new_key[63:56]))
        else $error("canonical pair out of order");
`endif

endmodule

// ===== verif/gf2_tableau_rotate_canonicalize_core_test.sv =====
// ----------------------------------------------------------------------------
// gf2_tableau_rotate_canonicalize_core_test
// Self-checking bench for the tableau rotate/canonicalize core. A queue of
// rotations feeds a valid/ready driver. Each transfer is run through a
// behavioral rotate + canonicalize predictor, and a monitor compares every
// output transfer, field by field, against the oldest prediction. Both sides
// idle in random bursts, except in a closing run at full rate.
// ----------------------------------------------------------------------------
module gf2_tableau_rotate_canonicalize_core_test;
    import gtrc_pkg::*;

    typedef struct packed {
        key_t     key;
        rot_ctl_t ctl;
    } rot_item_t;

    typedef struct packed {
        key_t                          key;
        logic [NUM_QUBITS-1:0][2:0]    loc;
    } canon_t;

    localparam local_t WORD_ORDER [6] = '{LOC_NONE, LOC_H, LOC_S, LOC_HS, LOC_SH, LOC_HSH};
    localparam int     RANDOM_BURSTY = 350;
    localparam int     RANDOM_STEADY = 100;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [63:0] tableau_key = '0;
    logic [1:0]  qubit_a = '0;
    logic [1:0]  qubit_b = '0;
    logic [1:0]  axis_a = '0;
    logic [1:0]  axis_b = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] new_key;
    logic [2:0]  local_q0;
    logic [2:0]  local_q1;
    logic [2:0]  local_q2;
    logic [2:0]  local_q3;

    rot_item_t rotation_q [$];
    canon_t    canon_exp_q [$];
    rot_item_t on_bus;
    bit        no_idle = 1'b0;
    int        src_idle = 0;
    int        sink_idle = 0;
    int        mismatch_cnt = 0;
    int        items_sent = 0;
    int        results_checked = 0;
    int        same_qubit_cnt = 0;
    logic [5:0] words_seen = '0;

    gf2_tableau_rotate_canonicalize_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .tableau_key (tableau_key),
        .qubit_a     (qubit_a),
        .qubit_b     (qubit_b),
        .axis_a      (axis_a),
        .axis_b      (axis_b),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .new_key     (new_key),
        .local_q0    (local_q0),
        .local_q1    (local_q1),
        .local_q2    (local_q2),
        .local_q3    (local_q3)
    );

    always #10 clk = ~clk;

    // rotate the key, then sort each qubit's {x, z, x^z} and keep the two smallest
    function automatic canon_t predict_canon(input rot_item_t it);
        col_t   col [NUM_COLS];
        col_t   delta;
        col_t   x, z, lo, mid, hi, swp, tx, tz;
        int     xa, xb;
        bit     found;
        canon_t res;
        for (int i = 0; i < NUM_COLS; i++)
            col[i] = it.key[COL_W*i +: COL_W];
        xa = 2 * int'(it.ctl.qubit_a);
        xb = 2 * int'(it.ctl.qubit_b);
        // change byte comes from the columns before any update
        delta = '0;
        if (it.ctl.axis_a[AXIS_X_BIT]) delta ^= col[xa];
        if (it.ctl.axis_a[AXIS_Z_BIT]) delta ^= col[xa+1];
        if (it.ctl.axis_b[AXIS_X_BIT]) delta ^= col[xb];
        if (it.ctl.axis_b[AXIS_Z_BIT]) delta ^= col[xb+1];
        if (it.ctl.axis_a[AXIS_Z_BIT]) col[xa]   ^= delta;
        if (it.ctl.axis_a[AXIS_X_BIT]) col[xa+1] ^= delta;
        if (it.ctl.axis_b[AXIS_Z_BIT]) col[xb]   ^= delta;
        if (it.ctl.axis_b[AXIS_X_BIT]) col[xb+1] ^= delta;
        for (int q = 0; q < NUM_QUBITS; q++)
        begin
            x   = col[2*q];
            z   = col[2*q+1];
            lo  = x;
            mid = z;
            hi  = x ^ z;
            if (lo > mid)
            begin
                swp = lo;
                lo  = mid;
                mid = swp;
            end
            if (mid > hi)
            begin
                swp = mid;
                mid = hi;
                hi  = swp;
            end
            if (lo > mid)
            begin
                swp = lo;
                lo  = mid;
                mid = swp;
            end
            res.loc[q] = LOC_NONE;
            found = 1'b0;
            for (int k = 0; k < 6; k++)
            begin
                case (WORD_ORDER[k])
                    LOC_H:
                    begin
                        tx = z;
                        tz = x;
                    end
                    LOC_S:
                    begin
                        tx = x;
                        tz = x ^ z;
                    end
                    LOC_HS:
                    begin
                        tx = z;
                        tz = z ^ x;
                    end
                    LOC_SH:
                    begin
                        tx = x ^ z;
                        tz = x;
                    end
                    LOC_HSH:
                    begin
                        tx = x ^ z;
                        tz = z;
                    end
                    default:
                    begin
                        tx = x;
                        tz = z;
                    end
                endcase
                if (!found && tx == lo && tz == mid)
                begin
                    res.loc[q] = WORD_ORDER[k];
                    found = 1'b1;
                end
            end
            col[2*q]   = lo;
            col[2*q+1] = mid;
        end
        for (int i = 0; i < NUM_COLS; i++)
            res.key[COL_W*i +: COL_W] = col[i];
        return res;
    endfunction

    function automatic rot_item_t make_rotation(input key_t key, input int qa, input int qb,
                                                input int aa, input int ab);
        rot_item_t it;
        it.key         = key;
        it.ctl.qubit_a = qubit_t'(qa);
        it.ctl.qubit_b = qubit_t'(qb);
        it.ctl.axis_a  = axis_t'(aa);
        it.ctl.axis_b  = axis_t'(ab);
        return it;
    endfunction

    // mixes full-range, tiny and repeated columns so ties and zeros show up often
    function automatic rot_item_t random_rotation();
        key_t key;
        col_t c;
        int   qa, qb;
        c = '0;
        for (int i = 0; i < NUM_COLS; i++)
        begin
            case ($urandom_range(0, 5))
                0, 1, 2: c = col_t'($urandom);
                3:       c = col_t'($urandom_range(0, 3));
                4:       c = c;
                default: c = col_t'(8'hFF ^ $urandom_range(0, 3));
            endcase
            key[COL_W*i +: COL_W] = c;
        end
        qa = $urandom_range(0, 3);
        qb = ($urandom_range(0, 4) == 0) ? qa : $urandom_range(0, 3);
        return make_rotation(key, qa, qb, $urandom_range(0, 3), $urandom_range(0, 3));
    endfunction

    task automatic queue_rotation(input rot_item_t it);
        rotation_q = {rotation_q, it};
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %0s, result %0d: got %h, want %h",
                 $realtime, what, results_checked, got, want);
        mismatch_cnt++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            src_idle <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                canon_exp_q = {canon_exp_q, predict_canon(on_bus)};
                items_sent++;
                if (on_bus.ctl.qubit_a == on_bus.ctl.qubit_b)
                    same_qubit_cnt++;
            end
            if (in_valid && !in_ready)
            begin
                // hold the pending transfer
            end
            else if (src_idle != 0)
            begin
                src_idle <= src_idle - 1;
                in_valid <= 1'b0;
            end
            else if (!no_idle && rotation_q.size() != 0 && $urandom_range(0, 11) == 0)
            begin
                src_idle <= $urandom_range(0, 17);
                in_valid <= 1'b0;
            end
            else if (rotation_q.size() != 0)
            begin
                on_bus = rotation_q.pop_front();
                tableau_key <= on_bus.key;
                qubit_a     <= on_bus.ctl.qubit_a;
                qubit_b     <= on_bus.ctl.qubit_b;
                axis_a      <= on_bus.ctl.axis_a;
                axis_b      <= on_bus.ctl.axis_b;
                in_valid    <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        canon_t                     want;
        logic [NUM_QUBITS-1:0][2:0] got_loc;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_idle <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_loc = {local_q3, local_q2, local_q1, local_q0};
                if (canon_exp_q.size() == 0)
                begin
                    report_mismatch("unexpected transfer", new_key, '0);
                end
                else
                begin
                    want = canon_exp_q.pop_front();
                    if (new_key !== want.key)
                        report_mismatch("new_key", new_key, want.key);
                    for (int q = 0; q < NUM_QUBITS; q++)
                    begin
                        if (got_loc[q] !== want.loc[q])
                            report_mismatch($sformatf("local_q%0d", q), 64'(got_loc[q]),
                                            64'(want.loc[q]));
                        words_seen[want.loc[q]] = 1'b1;
                    end
                end
                results_checked++;
            end
            if (sink_idle != 0)
            begin
                sink_idle <= sink_idle - 1;
                out_ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                sink_idle <= $urandom_range(0, 17);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        // every local word at least once, no rotation applied
        queue_rotation(make_rotation(64'h0103_0301_0102_0201, 0, 1, 0, 0));
        queue_rotation(make_rotation(64'h0500_0000_0203_0302, 2, 3, 0, 0));
        // key extremes
        queue_rotation(make_rotation(64'h0, 0, 1, 3, 3));
        queue_rotation(make_rotation(64'hFFFF_FFFF_FFFF_FFFF, 3, 2, 3, 3));
        queue_rotation(make_rotation(64'hAAAA_AAAA_AAAA_AAAA, 0, 3, 2, 1));
        queue_rotation(make_rotation(64'h5555_5555_5555_5555, 3, 0, 1, 2));
        // same qubit on both sides: a column selected by both masks cancels
        queue_rotation(make_rotation(64'h1234_5678_9ABC_DEF0, 2, 2, 3, 3));
        queue_rotation(make_rotation(64'h0F1E_2D3C_4B5A_6978, 1, 1, 2, 1));
        queue_rotation(make_rotation(64'hC3A5_5AC3_FF00_8001, 1, 1, 1, 1));
        queue_rotation(make_rotation(64'h8040_2010_0804_0201, 3, 3, 2, 2));
        queue_rotation(make_rotation(64'h7E81_00FF_3CC3_6699, 0, 0, 3, 1));
        // one side with an empty mask
        queue_rotation(make_rotation(64'hDEAD_BEEF_CAFE_F00D, 0, 2, 0, 3));
        queue_rotation(make_rotation(64'hDEAD_BEEF_CAFE_F00D, 1, 3, 3, 0));
        // ties: equal columns and zero columns
        queue_rotation(make_rotation(64'h0707_0000_3333_0101, 1, 3, 0, 0));
        queue_rotation(make_rotation(64'h0700_0007_3300_0033, 0, 2, 2, 2));
        for (int q = 0; q < 4; q++)
            queue_rotation(make_rotation({$urandom, $urandom}, q, 3 - q, q, 3 - q));

        // hold the sender off until the pipe is fully drained
        while (!(rotation_q.size() == 0 && !in_valid && canon_exp_q.size() == 0))
            @(negedge clk);

        for (int n = 0; n < RANDOM_BURSTY; n++)
            queue_rotation(random_rotation());
        while (rotation_q.size() != 0)
            @(negedge clk);

        // closing run at full rate on both sides
        no_idle = 1'b1;
        for (int n = 0; n < RANDOM_STEADY; n++)
            queue_rotation(random_rotation());

        while (!(rotation_q.size() == 0 && !in_valid && canon_exp_q.size() == 0))
            @(negedge clk);
        repeat (10) @(posedge clk);
        if (canon_exp_q.size() != 0)
            report_mismatch("missing results", 64'(canon_exp_q.size()), '0);

        $display("%0d rotations sent (%0d on a single qubit), %0d results checked",
                 items_sent, same_qubit_cnt, results_checked);
        $display("local words observed (bit per index 5..0): %b", words_seen);
        if (mismatch_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("timeout with %0d results outstanding", canon_exp_q.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/gtrc_pkg.sv
rtl/gtrc_rotate.sv
rtl/gtrc_canon.sv
rtl/gf2_tableau_rotate_canonicalize_core.sv
verif/gf2_tableau_rotate_canonicalize_core_test.sv
